/* rtl/tdpc_pkg.sv */
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared widths, limits and the divider status bundle of the prime counter
// ----------------------------------------------------------------------------
package tdpc_pkg;

  // width of the limit register
  localparam int unsigned LIMIT_W = 32;

  // width of the running prime count
  localparam int unsigned COUNT_W = 28;

  // saturation value of the prime count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // status returned by the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/tdpc_divider.sv */
// ----------------------------------------------------------------------------
// tdpc_divider
// bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifts out at the top while quotient bits shift in at the bottom
// ----------------------------------------------------------------------------
module tdpc_divider
  import tdpc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output div_stat_t              stat_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH+1:0] trial;
  logic [VALUE_WIDTH+1:0] diff;
  logic                   borrow;

  // one restoring step: bring down the next dividend bit and try a subtract
  assign trial  = {1'b0, rem_q, num_q[VALUE_WIDTH-1]};
  assign diff   = trial - {2'b00, div_q};
  assign borrow = diff[VALUE_WIDTH+1];

  // step sequencing
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[VALUE_WIDTH-2:0], ~borrow};
      rem_d = borrow ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = num_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/trial_division_prime_counter.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_counter
// primality test by trial division over odd divisors, with a saturating
// running count of primes and a configurable upper limit
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | value_i, clear_count_i
//  out     | output    | out_valid_o/out_ready_i | is_prime_o, above_limit_o,
//          |           |                         | prime_count_o
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (upper_limit)
//
//  steps: a classify state, then one divide in the bit-serial divider per odd
//    trial divisor, up to about sqrt(n)/2 divisors for a prime n, then a done
//    state that hands the result to the output register
//  one item at a time: in_ready_o is high only while no item is in work
//  a finished result waits in the output register while the next item is taken
//  reset clears the count and sets the limit to all ones, no clearing pass
// ----------------------------------------------------------------------------
module trial_division_prime_counter
  import tdpc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LIMIT_W-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   clear_count_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_prime_o,
  output logic                   above_limit_o,
  output logic [COUNT_W-1:0]     prime_count_o
);

  localparam int unsigned CMP_W = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
  localparam logic [VALUE_WIDTH-1:0] FIRST_DIV = VALUE_WIDTH'(3);
  localparam logic [VALUE_WIDTH-1:0] DIV_STEP  = VALUE_WIDTH'(2);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_CLASSIFY = 2'd1;
  localparam logic [1:0] S_DIV      = 2'd2;
  localparam logic [1:0] S_DONE     = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [LIMIT_W-1:0]     limit_q;
  logic [COUNT_W-1:0]     total_q, total_d;
  logic                   prime_q, prime_d;
  logic                   above_q, above_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic                   in_fire;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [VALUE_WIDTH-1:0] div_rem;

  // serial divider shared by every trial divisor
  tdpc_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_d),
    .stat_o     (div_stat),
    .quotient_o (div_quot),
    .remainder_o(div_rem)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // item sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    prime_d   = prime_q;
    above_d   = above_q;
    total_d   = total_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d     = value_i;
          state_d = S_CLASSIFY;
          if (clear_count_i) begin
            total_d = '0;
          end
        end
      end
      S_CLASSIFY: begin
        prime_d = 1'b0;
        above_d = 1'b0;
        priority if (CMP_W'(n_q) > CMP_W'(limit_q)) begin
          above_d = 1'b1;
          state_d = S_DONE;
        end else if (n_q <= VALUE_WIDTH'(1)) begin
          state_d = S_DONE;
        end else if (n_q == DIV_STEP) begin
          prime_d = 1'b1;
          state_d = S_DONE;
        end else if (!n_q[0]) begin
          state_d = S_DONE;
        end else begin
          // odd value of three or more: first trial divisor
          d_d       = FIRST_DIV;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          priority if (d_q > div_quot) begin
            // divisor squared beyond n: no factor exists
            prime_d = 1'b1;
            state_d = S_DONE;
          end else if (div_rem == '0) begin
            state_d = S_DONE;
          end else begin
            d_d       = d_q + DIV_STEP;
            div_start = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
          if (prime_q && (total_q != COUNT_MAX)) begin
            total_d = total_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= {LIMIT_W{1'b1}};
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    prime_q <= prime_d;
    above_q <= above_d;
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      is_prime_o    <= prime_q;
      above_limit_o <= above_q;
      prime_count_o <= total_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a prime result never carries the above-limit flag
  a_prime_not_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_prime_o && above_limit_o))
    else $error("prime result flagged above limit");

  // a prime result always shows a nonzero count
  a_prime_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_prime_o) |-> (prime_count_o != '0))
    else $error("prime result with zero count");

  // divider completes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider done outside trial state");

  // trial divisors stay odd
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> d_q[0])
    else $error("even trial divisor");

  // a divide is running or finishing whenever the sequencer waits on it
  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("trial state with idle divider");

endmodule
